// ----- hw/rtl/cbl_pkg.sv -----
// Shared types and constants for the color blob locator.
`timescale 1ns / 1ps
package cbl_pkg;

   localparam int CSR_ADDR_BITS = 3;
   localparam int COLOR_BITS    = 8;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_REGION_LEFT   = 3'd0,
      CSR_REGION_TOP    = 3'd1,
      CSR_REGION_RIGHT  = 3'd2,
      CSR_REGION_BOTTOM = 3'd3,
      CSR_MIN_PIXELS    = 3'd4,
      CSR_COLOR_TOL     = 3'd5
   } csr_index_type;

   localparam int RESET_REGION_LEFT   = 0;
   localparam int RESET_REGION_TOP    = 0;
   localparam int RESET_REGION_RIGHT  = 1920;
   localparam int RESET_REGION_BOTTOM = 1080;
   localparam int RESET_MIN_PIXELS    = 10000;
   localparam int RESET_COLOR_TOL     = 20;

   // Reference colors
   localparam int REF_A_RED   = 54;
   localparam int REF_A_GREEN = 183;
   localparam int REF_A_BLUE  = 82;
   localparam int REF_B_RED   = 20;
   localparam int REF_B_GREEN = 61;
   localparam int REF_B_BLUE  = 11;

   // Green-dominance rule
   localparam int GREEN_MARGIN = 40;
   localparam int GREEN_FLOOR  = 90;

   // Box span (max - min) of at least 80 in x and at least 30 in y
   localparam int BOX_MIN_SPAN_X = 80;
   localparam int BOX_MIN_SPAN_Y = 30;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_EVAL,
      ST_DIV_X,
      ST_DIV_Y,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- hw/rtl/cbl_front.sv -----
// Front end: accepts pixels, classifies them and hands matches and frame ends on.
`timescale 1ns / 1ps
module cbl_front #(
   parameter int COORD_BITS = 15
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [COORD_BITS-1:0]       req_pixel_x,
   input  logic signed [COORD_BITS-1:0]       req_pixel_y,
   input  logic [cbl_pkg::COLOR_BITS-1:0]     req_red,
   input  logic [cbl_pkg::COLOR_BITS-1:0]     req_green,
   input  logic [cbl_pkg::COLOR_BITS-1:0]     req_blue,
   input  logic                               req_frame_end,
   input  logic signed [COORD_BITS-1:0]       region_left,
   input  logic signed [COORD_BITS-1:0]       region_top,
   input  logic signed [COORD_BITS-1:0]       region_right,
   input  logic signed [COORD_BITS-1:0]       region_bottom,
   input  logic [cbl_pkg::COLOR_BITS-1:0]     color_tol,
   output logic                               push_valid,
   input  logic                               queue_full,
   output logic signed [COORD_BITS-1:0]       push_x,
   output logic signed [COORD_BITS-1:0]       push_y,
   output logic                               push_match,
   output logic                               push_last
);
   import cbl_pkg::*;

   logic                         hold_valid_ff, hold_valid_in;
   logic signed [COORD_BITS-1:0] hold_x_ff, hold_y_ff;
   logic                         hold_match_ff, hold_last_ff;
   logic                         accept;
   logic                         in_region;
   logic                         near_a, near_b, green_rule;
   logic                         is_match;

   function automatic logic near_ref(
      input logic [COLOR_BITS-1:0] r,
      input logic [COLOR_BITS-1:0] g,
      input logic [COLOR_BITS-1:0] b,
      input logic [COLOR_BITS-1:0] tr,
      input logic [COLOR_BITS-1:0] tg,
      input logic [COLOR_BITS-1:0] tb,
      input logic [COLOR_BITS-1:0] tol
   );
      logic [COLOR_BITS-1:0] dr, dg, db;
      dr = (r > tr) ? r - tr : tr - r;
      dg = (g > tg) ? g - tg : tg - g;
      db = (b > tb) ? b - tb : tb - b;
      return (dr <= tol) && (dg <= tol) && (db <= tol);
   endfunction

   assign in_region = (req_pixel_x >= region_left) && (req_pixel_x < region_right) &&
                      (req_pixel_y >= region_top) && (req_pixel_y < region_bottom);

   assign near_a = near_ref(req_red, req_green, req_blue, COLOR_BITS'(REF_A_RED),
                            COLOR_BITS'(REF_A_GREEN), COLOR_BITS'(REF_A_BLUE), color_tol);
   assign near_b = near_ref(req_red, req_green, req_blue, COLOR_BITS'(REF_B_RED),
                            COLOR_BITS'(REF_B_GREEN), COLOR_BITS'(REF_B_BLUE), color_tol);

   // One extra bit so red + margin cannot wrap
   assign green_rule =
      ({1'b0, req_green} > ({1'b0, req_red} + (COLOR_BITS+1)'(GREEN_MARGIN))) &&
      ({1'b0, req_green} > ({1'b0, req_blue} + (COLOR_BITS+1)'(GREEN_MARGIN))) &&
      (req_green > COLOR_BITS'(GREEN_FLOOR));

   assign is_match  = in_region && (near_a || near_b || green_rule);

   assign req_stall = hold_valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;

   // Drop pixels that neither match nor close the frame
   always_comb begin
      if (accept) begin
         hold_valid_in = is_match || req_frame_end;
      end else begin
         hold_valid_in = hold_valid_ff && queue_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_x_ff     <= req_pixel_x;
         hold_y_ff     <= req_pixel_y;
         hold_match_ff <= is_match;
         hold_last_ff  <= req_frame_end;
      end
   end

   assign push_valid = hold_valid_ff;
   assign push_x     = hold_x_ff;
   assign push_y     = hold_y_ff;
   assign push_match = hold_match_ff;
   assign push_last  = hold_last_ff;

endmodule

// ----- hw/rtl/cbl_fifo.sv -----
// Short queue between the classifying front and the accumulating back.
`timescale 1ns / 1ps
module cbl_fifo #(
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output logic [DATA_BITS-1:0] pop_data
);
   import cbl_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   logic [DATA_BITS-1:0] entries_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]    count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == (PTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/cbl_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
`timescale 1ns / 1ps
module cbl_div #(
   parameter int DIVIDEND_BITS = 40,
   parameter int DIVISOR_BITS  = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DIVIDEND_BITS-1:0]     dividend,
   input  logic [DIVISOR_BITS-1:0]      divisor,
   output cbl_pkg::div_status_type      status,
   output logic [DIVIDEND_BITS-1:0]     quotient
);
   import cbl_pkg::*;

   localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_BITS:0]    shifted;
   logic [DIVISOR_BITS:0]    diff;
   logic                     fits;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_BITS'(DIVIDEND_BITS);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
         quo_in  = {quo_ff[DIVIDEND_BITS-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ----- hw/rtl/cbl_back.sv -----
// Back end: accumulates matches, forms the frame result and holds it for the consumer.
`timescale 1ns / 1ps
module cbl_back #(
   parameter int COORD_BITS = 15,
   parameter int COUNT_BITS = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    pop_valid,
   output logic                                    pop,
   input  logic signed [COORD_BITS-1:0]            pop_x,
   input  logic signed [COORD_BITS-1:0]            pop_y,
   input  logic                                    pop_match,
   input  logic                                    pop_last,
   input  logic [COUNT_BITS-1:0]                   min_pixels,
   output logic                                    div_start,
   output logic [COUNT_BITS+COORD_BITS:0]          div_dividend,
   output logic [COUNT_BITS-1:0]                   div_divisor,
   input  cbl_pkg::div_status_type                 div_status,
   input  logic [COUNT_BITS+COORD_BITS:0]          div_quotient,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_target_found,
   output logic signed [COORD_BITS-1:0]            rsp_target_x,
   output logic signed [COORD_BITS-1:0]            rsp_target_y,
   output logic                                    rsp_used_centroid,
   output logic [COUNT_BITS-1:0]                   rsp_matched_count
);
   import cbl_pkg::*;

   localparam int SUM_BITS = COUNT_BITS + COORD_BITS + 1;
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic signed [SUM_BITS-1:0]   SUM_MAX   = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0]   SUM_MIN   = {1'b1, {(SUM_BITS-1){1'b0}}};
   localparam logic [SUM_BITS-1:0] POS_LIMIT = {{(SUM_BITS-COORD_BITS+1){1'b0}},
                                                {(COORD_BITS-1){1'b1}}};
   localparam logic [SUM_BITS-1:0] NEG_LIMIT = {{(SUM_BITS-COORD_BITS){1'b0}}, 1'b1,
                                                {(COORD_BITS-1){1'b0}}};
   localparam logic signed [COORD_BITS:0] SPAN_X_MIN = (COORD_BITS+1)'(BOX_MIN_SPAN_X);
   localparam logic signed [COORD_BITS:0] SPAN_Y_MIN = (COORD_BITS+1)'(BOX_MIN_SPAN_Y);

   back_state_type               state_ff, state_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic signed [SUM_BITS-1:0]   sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic signed [COORD_BITS-1:0] min_x_ff, min_x_in, min_y_ff, min_y_in;
   logic signed [COORD_BITS-1:0] max_x_ff, max_x_in, max_y_ff, max_y_in;
   logic                         found_ff, found_in, cent_ff, cent_in;
   logic signed [COORD_BITS-1:0] tx_ff, tx_in, ty_ff, ty_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_cent_ff;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic [COUNT_BITS-1:0]        rsp_count_ff;

   logic                         enough, box_ok, use_centroid;
   logic signed [COORD_BITS:0]   span_x, span_y, pair_x, pair_y, round_x, round_y;
   logic signed [COORD_BITS-1:0] mid_x, mid_y;
   logic                         neg_x, neg_y;
   logic [SUM_BITS-1:0]          mag_x, mag_y;
   logic                         out_free, emit;

   function automatic logic signed [SUM_BITS-1:0] sat_add(
      input logic signed [SUM_BITS-1:0]   s,
      input logic signed [COORD_BITS-1:0] v
   );
      logic signed [SUM_BITS:0] t;
      t = $signed({s[SUM_BITS-1], s}) + (SUM_BITS+1)'(v);
      if (t[SUM_BITS] != t[SUM_BITS-1]) begin
         return t[SUM_BITS] ? SUM_MIN : SUM_MAX;
      end
      return t[SUM_BITS-1:0];
   endfunction

   // Clamp a quotient magnitude to the coordinate range, then apply the sign
   function automatic logic signed [COORD_BITS-1:0] to_coord(
      input logic [SUM_BITS-1:0] mag,
      input logic                neg
   );
      logic [SUM_BITS-1:0] lim;
      logic [SUM_BITS-1:0] m;
      lim = neg ? NEG_LIMIT : POS_LIMIT;
      m   = (mag > lim) ? lim : mag;
      m   = neg ? (~m + 1'b1) : m;
      return m[COORD_BITS-1:0];
   endfunction

   // Frame decision
   assign span_x = $signed({max_x_ff[COORD_BITS-1], max_x_ff}) -
                   $signed({min_x_ff[COORD_BITS-1], min_x_ff});
   assign span_y = $signed({max_y_ff[COORD_BITS-1], max_y_ff}) -
                   $signed({min_y_ff[COORD_BITS-1], min_y_ff});
   assign enough       = (count_ff >= min_pixels);
   assign box_ok       = (span_x >= SPAN_X_MIN) && (span_y >= SPAN_Y_MIN);
   assign use_centroid = enough && !box_ok && (count_ff != '0);

   // Box centre, halved toward zero
   assign pair_x  = $signed({min_x_ff[COORD_BITS-1], min_x_ff}) +
                    $signed({max_x_ff[COORD_BITS-1], max_x_ff});
   assign pair_y  = $signed({min_y_ff[COORD_BITS-1], min_y_ff}) +
                    $signed({max_y_ff[COORD_BITS-1], max_y_ff});
   assign round_x = pair_x + $signed({{COORD_BITS{1'b0}}, pair_x[COORD_BITS]});
   assign round_y = pair_y + $signed({{COORD_BITS{1'b0}}, pair_y[COORD_BITS]});
   assign mid_x   = round_x[COORD_BITS:1];
   assign mid_y   = round_y[COORD_BITS:1];

   assign neg_x = sum_x_ff[SUM_BITS-1];
   assign neg_y = sum_y_ff[SUM_BITS-1];
   assign mag_x = neg_x ? (~sum_x_ff + 1'b1) : sum_x_ff;
   assign mag_y = neg_y ? (~sum_y_ff + 1'b1) : sum_y_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCUM: begin
            if (pop_valid && pop_last) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = use_centroid ? ST_DIV_X : ST_EMIT;
         end
         ST_DIV_X: begin
            if (div_status.done) begin
               state_in = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_status.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   // State outputs
   always_comb begin
      pop          = 1'b0;
      div_start    = 1'b0;
      div_dividend = mag_x;
      emit         = 1'b0;
      case (state_ff)
         ST_ACCUM: begin
            pop = pop_valid;
         end
         ST_EVAL: begin
            div_start = use_centroid;
         end
         ST_DIV_X: begin
            div_start    = div_status.done;
            div_dividend = mag_y;
         end
         ST_DIV_Y: begin
            div_dividend = mag_y;
         end
         ST_EMIT: begin
            emit = out_free;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   assign div_divisor = count_ff;

   // Accumulators and result staging
   always_comb begin
      count_in = count_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      min_x_in = min_x_ff;
      min_y_in = min_y_ff;
      max_x_in = max_x_ff;
      max_y_in = max_y_ff;
      found_in = found_ff;
      cent_in  = cent_ff;
      tx_in    = tx_ff;
      ty_in    = ty_ff;
      if (pop && pop_match) begin
         if (count_ff != '1) begin
            count_in = count_ff + 1'b1;
         end
         sum_x_in = sat_add(sum_x_ff, pop_x);
         sum_y_in = sat_add(sum_y_ff, pop_y);
         if (pop_x < min_x_ff) min_x_in = pop_x;
         if (pop_y < min_y_ff) min_y_in = pop_y;
         if (pop_x > max_x_ff) max_x_in = pop_x;
         if (pop_y > max_y_ff) max_y_in = pop_y;
      end
      if (state_ff == ST_EVAL) begin
         found_in = enough && (box_ok || (count_ff != '0));
         cent_in  = use_centroid;
         tx_in    = (enough && box_ok) ? mid_x : '0;
         ty_in    = (enough && box_ok) ? mid_y : '0;
      end
      if (state_ff == ST_DIV_X && div_status.done) begin
         tx_in = to_coord(div_quotient, neg_x);
      end
      if (state_ff == ST_DIV_Y && div_status.done) begin
         ty_in = to_coord(div_quotient, neg_y);
      end
      // Start the next frame once the result is handed over
      if (emit) begin
         count_in = '0;
         sum_x_in = '0;
         sum_y_in = '0;
         min_x_in = COORD_MAX;
         min_y_in = COORD_MAX;
         max_x_in = COORD_MIN;
         max_y_in = COORD_MIN;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         count_ff     <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         min_x_ff     <= COORD_MAX;
         min_y_ff     <= COORD_MAX;
         max_x_ff     <= COORD_MIN;
         max_y_ff     <= COORD_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         min_x_ff     <= min_x_in;
         min_y_ff     <= min_y_in;
         max_x_ff     <= max_x_in;
         max_y_ff     <= max_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      cent_ff  <= cent_in;
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      if (emit) begin
         rsp_found_ff <= found_ff;
         rsp_cent_ff  <= cent_ff;
         rsp_x_ff     <= tx_ff;
         rsp_y_ff     <= ty_ff;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_target_found  = rsp_found_ff;
   assign rsp_target_x      = rsp_x_ff;
   assign rsp_target_y      = rsp_y_ff;
   assign rsp_used_centroid = rsp_cent_ff;
   assign rsp_matched_count = rsp_count_ff;

endmodule

// ----- hw/rtl/color_blob_locator.sv -----
// Top level of the color blob locator: registers, front, queue, back and divider.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+------------------------------------------
//   req_    | in        | req_valid/stall   | pixel_x, pixel_y, red, green, blue, frame_end
//   rsp_    | out       | rsp_valid/stall   | target_found, target_x, target_y,
//           |           |                   | used_centroid, matched_count
//   csr_    | in        | csr_we            | csr_addr, csr_wdata
//
// Pixels are taken one per cycle while req_stall is low; the back end takes one queued
// match or frame end per cycle while it accumulates. A box or empty result at a frame
// end needs no division; a centroid is divided out bit by bit in the shared divider,
// x then y.
// Meanwhile the front keeps taking pixels until its hold register and 4-entry queue fill.
// Reset is synchronous and needs no clearing pass.
// The result sits in an output register, so a stalled rsp_ side holds the back end only when its next result is ready.
`timescale 1ns / 1ps
module color_blob_locator #(
   parameter int COORD_BITS = 15,
   parameter int COUNT_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [COORD_BITS-1:0]         req_pixel_x,
   input  logic signed [COORD_BITS-1:0]         req_pixel_y,
   input  logic [cbl_pkg::COLOR_BITS-1:0]       req_red,
   input  logic [cbl_pkg::COLOR_BITS-1:0]       req_green,
   input  logic [cbl_pkg::COLOR_BITS-1:0]       req_blue,
   input  logic                                 req_frame_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_target_found,
   output logic signed [COORD_BITS-1:0]         rsp_target_x,
   output logic signed [COORD_BITS-1:0]         rsp_target_y,
   output logic                                 rsp_used_centroid,
   output logic [COUNT_BITS-1:0]                rsp_matched_count,
   input  logic                                 csr_we,
   input  logic [cbl_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  logic [COUNT_BITS-1:0]                csr_wdata
);
   import cbl_pkg::*;

   localparam int SUM_BITS  = COUNT_BITS + COORD_BITS + 1;
   localparam int ITEM_BITS = 2 * COORD_BITS + 2;

   logic signed [COORD_BITS-1:0] region_left_ff, region_top_ff;
   logic signed [COORD_BITS-1:0] region_right_ff, region_bottom_ff;
   logic [COUNT_BITS-1:0]        min_pixels_ff;
   logic [COLOR_BITS-1:0]        color_tol_ff;

   logic                         push_valid, queue_full, push_match, push_last;
   logic signed [COORD_BITS-1:0] push_x, push_y;
   logic [ITEM_BITS-1:0]         push_data, pop_data;
   logic                         pop, pop_valid;
   logic signed [COORD_BITS-1:0] pop_x, pop_y;
   logic                         pop_match, pop_last;

   logic                         div_start;
   logic [SUM_BITS-1:0]          div_dividend, div_quotient;
   logic [COUNT_BITS-1:0]        div_divisor;
   div_status_type               div_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_left_ff   <= COORD_BITS'(RESET_REGION_LEFT);
         region_top_ff    <= COORD_BITS'(RESET_REGION_TOP);
         region_right_ff  <= COORD_BITS'(RESET_REGION_RIGHT);
         region_bottom_ff <= COORD_BITS'(RESET_REGION_BOTTOM);
         min_pixels_ff    <= COUNT_BITS'(RESET_MIN_PIXELS);
         color_tol_ff     <= COLOR_BITS'(RESET_COLOR_TOL);
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_REGION_LEFT:   region_left_ff   <= csr_wdata[COORD_BITS-1:0];
            CSR_REGION_TOP:    region_top_ff    <= csr_wdata[COORD_BITS-1:0];
            CSR_REGION_RIGHT:  region_right_ff  <= csr_wdata[COORD_BITS-1:0];
            CSR_REGION_BOTTOM: region_bottom_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_MIN_PIXELS:    min_pixels_ff    <= csr_wdata;
            CSR_COLOR_TOL:     color_tol_ff     <= csr_wdata[COLOR_BITS-1:0];
            default: begin
               // writes past the register list are ignored
            end
         endcase
      end
   end

   cbl_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel_x   (req_pixel_x),
      .req_pixel_y   (req_pixel_y),
      .req_red       (req_red),
      .req_green     (req_green),
      .req_blue      (req_blue),
      .req_frame_end (req_frame_end),
      .region_left   (region_left_ff),
      .region_top    (region_top_ff),
      .region_right  (region_right_ff),
      .region_bottom (region_bottom_ff),
      .color_tol     (color_tol_ff),
      .push_valid    (push_valid),
      .queue_full    (queue_full),
      .push_x        (push_x),
      .push_y        (push_y),
      .push_match    (push_match),
      .push_last     (push_last)
   );

   assign push_data = {push_x, push_y, push_match, push_last};

   cbl_fifo #(
      .DATA_BITS (ITEM_BITS)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   assign pop_x     = $signed(pop_data[ITEM_BITS-1 -: COORD_BITS]);
   assign pop_y     = $signed(pop_data[COORD_BITS+1 -: COORD_BITS]);
   assign pop_match = pop_data[1];
   assign pop_last  = pop_data[0];

   cbl_back #(
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop               (pop),
      .pop_x             (pop_x),
      .pop_y             (pop_y),
      .pop_match         (pop_match),
      .pop_last          (pop_last),
      .min_pixels        (min_pixels_ff),
      .div_start         (div_start),
      .div_dividend      (div_dividend),
      .div_divisor       (div_divisor),
      .div_status        (div_status),
      .div_quotient      (div_quotient),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_target_found  (rsp_target_found),
      .rsp_target_x      (rsp_target_x),
      .rsp_target_y      (rsp_target_y),
      .rsp_used_centroid (rsp_used_centroid),
      .rsp_matched_count (rsp_matched_count)
   );

   cbl_div #(
      .DIVIDEND_BITS (SUM_BITS),
      .DIVISOR_BITS  (COUNT_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // The front only stalls when its hold register cannot drain into the queue
   assert property (@(posedge clock) disable iff (reset) req_stall |-> queue_full)
      else $error("req_stall raised while the queue has room");

   // A new division never starts on top of one in flight
   assert property (@(posedge clock) disable iff (reset) div_start |-> !div_status.busy)
      else $error("divider restarted while busy");

   // An empty result carries zero position and no centroid flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_target_found) |->
         (rsp_target_x == '0 && rsp_target_y == '0 && !rsp_used_centroid))
      else $error("not-found result with nonzero position");

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for color_blob_locator: pixel frames against a built-in blob predictor.
`timescale 1ns / 1ps
module tb_top;
   import cbl_pkg::*;

   localparam int COORD_BITS   = 15;
   localparam int COUNT_BITS   = 24;
   localparam int SUM_BITS     = COUNT_BITS + COORD_BITS + 1;
   localparam longint SUM_MAX  = (longint'(1) <<< (SUM_BITS - 1)) - 1;
   localparam longint SUM_MIN  = -(longint'(1) <<< (SUM_BITS - 1));
   localparam int COORD_MAX    = (1 <<< (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN    = -(1 <<< (COORD_BITS - 1));
   localparam int COUNT_MAX    = (1 <<< COUNT_BITS) - 1;
   localparam int GAP_MAX      = 19;
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 2000;
   localparam int PHASES       = 10;
   localparam int PHASE_PIXELS = 160;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [COLOR_BITS-1:0]        r;
      logic [COLOR_BITS-1:0]        g;
      logic [COLOR_BITS-1:0]        b;
      logic                         last;
   } pixel_t;

   typedef struct packed {
      logic                         found;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic                         centroid;
      logic [COUNT_BITS-1:0]        count;
   } blob_report_t;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [COORD_BITS-1:0]  req_pixel_x;
   logic signed [COORD_BITS-1:0]  req_pixel_y;
   logic [COLOR_BITS-1:0]         req_red;
   logic [COLOR_BITS-1:0]         req_green;
   logic [COLOR_BITS-1:0]         req_blue;
   logic                          req_frame_end;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic                          rsp_target_found;
   logic signed [COORD_BITS-1:0]  rsp_target_x;
   logic signed [COORD_BITS-1:0]  rsp_target_y;
   logic                          rsp_used_centroid;
   logic [COUNT_BITS-1:0]         rsp_matched_count;
   logic                          csr_we;
   logic [CSR_ADDR_BITS-1:0]      csr_addr;
   logic [COUNT_BITS-1:0]         csr_wdata;

   // Predictor copy of the registers and of the per-frame accumulators
   logic signed [COORD_BITS-1:0]  cfg_left, cfg_top, cfg_right, cfg_bottom;
   logic [COUNT_BITS-1:0]         cfg_min_pixels;
   logic [COLOR_BITS-1:0]         cfg_tolerance;
   logic [COUNT_BITS-1:0]         hits;
   longint                        sum_x, sum_y;
   int                            box_min_x, box_min_y, box_max_x, box_max_y;

   blob_report_t                  pending_reports[$];
   int                            mismatches = 0;
   bit                            fast_mode = 1'b0;
   int                            output_hold = 0;
   int                            stall_left = 0;
   int                            idle_cycles = 0;

   color_blob_locator #(
      .COORD_BITS(COORD_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_frame_end     (req_frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_target_found  (rsp_target_found),
      .rsp_target_x      (rsp_target_x),
      .rsp_target_y      (rsp_target_y),
      .rsp_used_centroid (rsp_used_centroid),
      .rsp_matched_count (rsp_matched_count),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_frame();
      hits      = '0;
      sum_x     = 0;
      sum_y     = 0;
      box_min_x = COORD_MAX;
      box_min_y = COORD_MAX;
      box_max_x = COORD_MIN;
      box_max_y = COORD_MIN;
   endfunction

   function automatic bit near_color(logic [COLOR_BITS-1:0] r, g, b, int rr, rg, rb);
      int dr, dg, db, tol;
      tol = cfg_tolerance;
      dr  = (int'(r) > rr) ? int'(r) - rr : rr - int'(r);
      dg  = (int'(g) > rg) ? int'(g) - rg : rg - int'(g);
      db  = (int'(b) > rb) ? int'(b) - rb : rb - int'(b);
      return dr <= tol && dg <= tol && db <= tol;
   endfunction

   function automatic bit is_blob_color(logic [COLOR_BITS-1:0] r, g, b);
      if (near_color(r, g, b, REF_A_RED, REF_A_GREEN, REF_A_BLUE) ||
          near_color(r, g, b, REF_B_RED, REF_B_GREEN, REF_B_BLUE))
         return 1'b1;
      return int'(g) > int'(r) + GREEN_MARGIN && int'(g) > int'(b) + GREEN_MARGIN &&
             int'(g) > GREEN_FLOOR;
   endfunction

   function automatic longint clamp_sum(longint v);
      return (v > SUM_MAX) ? SUM_MAX : (v < SUM_MIN) ? SUM_MIN : v;
   endfunction

   function automatic int clamp_coord(longint v);
      return (v > COORD_MAX) ? COORD_MAX : (v < COORD_MIN) ? COORD_MIN : int'(v);
   endfunction

   // Fold one accepted pixel into the frame; on frame end queue the report and restart
   function automatic void accumulate_pixel(pixel_t p);
      int           x, y;
      bit           wide_box;
      blob_report_t rep;
      x = p.x;
      y = p.y;
      if (x >= cfg_left && x < cfg_right && y >= cfg_top && y < cfg_bottom &&
          is_blob_color(p.r, p.g, p.b)) begin
         if (hits != COUNT_BITS'(COUNT_MAX))
            hits = hits + 1'b1;
         sum_x = clamp_sum(sum_x + x);
         sum_y = clamp_sum(sum_y + y);
         if (x < box_min_x) box_min_x = x;
         if (y < box_min_y) box_min_y = y;
         if (x > box_max_x) box_max_x = x;
         if (y > box_max_y) box_max_y = y;
      end
      if (!p.last)
         return;
      wide_box = box_max_x >= box_min_x && box_max_x - box_min_x >= BOX_MIN_SPAN_X &&
                 box_max_y >= box_min_y && box_max_y - box_min_y >= BOX_MIN_SPAN_Y;
      rep = '0;
      rep.count = hits;
      if (hits >= cfg_min_pixels && wide_box) begin
         rep.found = 1'b1;
         rep.x     = COORD_BITS'((box_min_x + box_max_x) / 2);
         rep.y     = COORD_BITS'((box_min_y + box_max_y) / 2);
      end else if (hits >= cfg_min_pixels && hits != 0) begin
         rep.found    = 1'b1;
         rep.centroid = 1'b1;
         rep.x        = COORD_BITS'(clamp_coord(sum_x / longint'(hits)));
         rep.y        = COORD_BITS'(clamp_coord(sum_y / longint'(hits)));
      end
      pending_reports.push_back(rep);
      clear_frame();
   endfunction

   // ---------------------------------------------------------------- drivers

   function automatic int rand_between(int lo, int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic pixel_t mk_pixel(int x, int y, int r, int g, int b, bit last);
      pixel_t p;
      p.x    = COORD_BITS'(x);
      p.y    = COORD_BITS'(y);
      p.r    = COLOR_BITS'(r);
      p.g    = COLOR_BITS'(g);
      p.b    = COLOR_BITS'(b);
      p.last = last;
      return p;
   endfunction

   task automatic drive_pixel(pixel_t p);
      int gap;
      gap = fast_mode ? 0 : $urandom_range(0, GAP_MAX);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_pixel_x   = p.x;
      req_pixel_y   = p.y;
      req_red       = p.r;
      req_green     = p.g;
      req_blue      = p.b;
      req_frame_end = p.last;
      req_valid     = 1'b1;
      do @(posedge clock); while (req_stall);
      accumulate_pixel(p);
   endtask

   // Drop valid, let every report drain, then give the back end time to settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = COUNT_BITS'(value);
      @(negedge clock);
      csr_we    = 1'b0;
      case (idx)
         CSR_REGION_LEFT:   cfg_left       = COORD_BITS'(value);
         CSR_REGION_TOP:    cfg_top        = COORD_BITS'(value);
         CSR_REGION_RIGHT:  cfg_right      = COORD_BITS'(value);
         CSR_REGION_BOTTOM: cfg_bottom     = COORD_BITS'(value);
         CSR_MIN_PIXELS:    cfg_min_pixels = COUNT_BITS'(value);
         CSR_COLOR_TOL:     cfg_tolerance  = COLOR_BITS'(value);
         default: ;
      endcase
   endtask

   task automatic set_config(int left, int top, int right, int bottom, int min_pix, int tol);
      wait_idle();
      write_csr(CSR_REGION_LEFT, left);
      write_csr(CSR_REGION_TOP, top);
      write_csr(CSR_REGION_RIGHT, right);
      write_csr(CSR_REGION_BOTTOM, bottom);
      write_csr(CSR_MIN_PIXELS, min_pix);
      write_csr(CSR_COLOR_TOL, tol);
   endtask

   // ---------------------------------------------------------------- response side

   initial begin : drive_rsp_stall
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (output_hold > 0) begin
            rsp_stall = 1'b1;
            output_hold--;
         end else if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   task automatic compare_field(string field, logic signed [39:0] want,
                                logic signed [39:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_reports
      blob_report_t want;
      if (rsp_valid && !rsp_stall) begin
         stall_left = fast_mode ? 0 : $urandom_range(0, GAP_MAX);
         if (pending_reports.size() == 0) begin
            $error("report with no frame pending: found %0d x %0d y %0d count %0d",
                   rsp_target_found, rsp_target_x, rsp_target_y, rsp_matched_count);
            mismatches++;
         end else begin
            want = pending_reports.pop_front();
            compare_field("target_found", want.found, rsp_target_found);
            compare_field("target_x", want.x, rsp_target_x);
            compare_field("target_y", want.y, rsp_target_y);
            compare_field("used_centroid", want.centroid, rsp_used_centroid);
            compare_field("matched_count", want.count, rsp_matched_count);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_reset_defaults();
      drive_pixel(mk_pixel(100, 100, 0, 0, 0, 1'b0));
      // final pixel matches and counts, but the default minimum is far off
      drive_pixel(mk_pixel(200, 200, REF_A_RED, REF_A_GREEN, REF_A_BLUE, 1'b1));
   endtask

   task automatic test_color_rules();
      set_config(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1, 20);
      // tolerance edge on both reference colors; third matches too, centroid x truncates to 0
      drive_pixel(mk_pixel(-3, -7, REF_A_RED, REF_A_GREEN, REF_A_BLUE, 1'b0));
      drive_pixel(mk_pixel(0, 2, REF_B_RED + 20, REF_B_GREEN + 20, REF_B_BLUE + 20, 1'b0));
      drive_pixel(mk_pixel(5, 5, REF_A_RED + 21, REF_A_GREEN, REF_A_BLUE, 1'b1));
      // green dominance just over and just under its margins
      drive_pixel(mk_pixel(-101, 0, 10, 91, 50, 1'b0));
      drive_pixel(mk_pixel(-20, 30, 50, 91, 50, 1'b0));
      drive_pixel(mk_pixel(500, 500, 51, 91, 50, 1'b0));
      drive_pixel(mk_pixel(600, 600, 0, 90, 0, 1'b1));
   endtask

   task automatic test_box_versus_centroid();
      drive_pixel(mk_pixel(0, 0, REF_A_RED, REF_A_GREEN, REF_A_BLUE, 1'b0));
      drive_pixel(mk_pixel(79, 30, REF_A_RED, REF_A_GREEN, REF_A_BLUE, 1'b1));
      drive_pixel(mk_pixel(0, 0, REF_A_RED, REF_A_GREEN, REF_A_BLUE, 1'b0));
      drive_pixel(mk_pixel(80, 30, REF_A_RED, REF_A_GREEN, REF_A_BLUE, 1'b1));
   endtask

   task automatic test_empty_region();
      // zero matches with a zero minimum must still report nothing found
      set_config(100, 0, 100, 50, 0, 20);
      drive_pixel(mk_pixel(100, 10, REF_A_RED, REF_A_GREEN, REF_A_BLUE, 1'b0));
      drive_pixel(mk_pixel(100, 10, REF_A_RED, REF_A_GREEN, REF_A_BLUE, 1'b1));
      set_config(0, 40, 200, 39, 0, 20);
      drive_pixel(mk_pixel(10, 40, REF_B_RED, REF_B_GREEN, REF_B_BLUE, 1'b1));
   endtask

   task automatic test_coord_extremes();
      set_config(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 2, 0);
      drive_pixel(mk_pixel(COORD_MIN, COORD_MIN, REF_A_RED, REF_A_GREEN, REF_A_BLUE, 1'b0));
      drive_pixel(mk_pixel(COORD_MAX - 1, COORD_MAX - 1,
                           REF_B_RED, REF_B_GREEN, REF_B_BLUE, 1'b0));
      // right edge is exclusive
      drive_pixel(mk_pixel(COORD_MAX, 0, REF_A_RED, REF_A_GREEN, REF_A_BLUE, 1'b1));
      set_config(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COUNT_MAX, 255);
      drive_pixel(mk_pixel(0, 0, 0, 0, 0, 1'b0));
      drive_pixel(mk_pixel(-1, -1, 255, 255, 255, 1'b1));
   endtask

   task automatic test_output_backpressure();
      int k;
      set_config(RESET_REGION_LEFT, RESET_REGION_TOP, RESET_REGION_RIGHT,
                 RESET_REGION_BOTTOM, 1, RESET_COLOR_TOL);
      output_hold = HOLD_CYCLES;
      fast_mode   = 1'b1;
      for (k = 0; k < 30; k++) begin
         if (k % 3 == 0)
            drive_pixel(mk_pixel(k * 10, k, REF_A_RED, REF_A_GREEN, REF_A_BLUE, 1'b1));
         else
            drive_pixel(mk_pixel(k * 10, k, $urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 255), 1'b1));
      end
      fast_mode = 1'b0;
   endtask

   function automatic int near_span(int a, int b);
      int lo, hi;
      lo = ((a < b) ? a : b) - 3;
      hi = ((a > b) ? a : b) + 2;
      if (lo < COORD_MIN) lo = COORD_MIN;
      if (hi > COORD_MAX) hi = COORD_MAX;
      return rand_between(lo, hi);
   endfunction

   function automatic int jitter(int base, int spread);
      int v;
      v = base + rand_between(-spread, spread);
      return (v < 0) ? 0 : (v > 255) ? 255 : v;
   endfunction

   // Pixel near or inside the region, mostly colored close to one of the match rules
   function automatic pixel_t frame_pixel();
      int spread, g;
      spread = int'(cfg_tolerance) + 2;
      g = rand_between(70, 255);
      case ($urandom_range(0, 3))
         0: return mk_pixel(near_span(cfg_left, cfg_right), near_span(cfg_top, cfg_bottom),
                            jitter(REF_A_RED, spread), jitter(REF_A_GREEN, spread),
                            jitter(REF_A_BLUE, spread), 1'b0);
         1: return mk_pixel(near_span(cfg_left, cfg_right), near_span(cfg_top, cfg_bottom),
                            jitter(REF_B_RED, spread), jitter(REF_B_GREEN, spread),
                            jitter(REF_B_BLUE, spread), 1'b0);
         2: return mk_pixel(near_span(cfg_left, cfg_right), near_span(cfg_top, cfg_bottom),
                            rand_between(0, g - 30), g, rand_between(0, g - 30), 1'b0);
         default: return mk_pixel(near_span(cfg_left, cfg_right),
                                  near_span(cfg_top, cfg_bottom), $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
      endcase
   endfunction

   task automatic randomize_config();
      int kind, left, top, right, bottom, min_pix, tol;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         left   = COORD_MIN;
         top    = COORD_MIN;
         right  = COORD_MAX;
         bottom = COORD_MAX;
      end else if (kind == 1) begin
         left   = rand_between(COORD_MIN + 60, COORD_MAX);
         top    = rand_between(COORD_MIN + 60, COORD_MAX);
         right  = left - rand_between(0, 50);
         bottom = top - rand_between(0, 50);
      end else begin
         left   = rand_between(COORD_MIN, COORD_MAX - 400);
         top    = rand_between(COORD_MIN, COORD_MAX - 120);
         right  = left + rand_between(20, 400);
         bottom = top + rand_between(10, 120);
      end
      min_pix = ($urandom_range(0, 9) == 0) ? $urandom_range(0, COUNT_MAX)
                                             : $urandom_range(0, 25);
      tol     = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 30);
      set_config(left, top, right, bottom, min_pix, tol);
   endtask

   task automatic test_random_frames();
      int     phase, sent, len, k;
      pixel_t p;
      for (phase = 0; phase < PHASES; phase++) begin
         randomize_config();
         fast_mode = ($urandom_range(0, 3) == 0);
         sent = 0;
         while (sent < PHASE_PIXELS) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 30);
            // keep the phase at its pixel budget
            if (len > PHASE_PIXELS - sent)
               len = PHASE_PIXELS - sent;
            for (k = 0; k < len; k++) begin
               if ($urandom_range(0, 6) == 0)
                  p = mk_pixel(rand_between(COORD_MIN, COORD_MAX),
                               rand_between(COORD_MIN, COORD_MAX), $urandom_range(0, 255),
                               $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 30) == 0);
               else
                  p = frame_pixel();
               if (k == len - 1)
                  p.last = 1'b1;
               drive_pixel(p);
               sent++;
            end
         end
         fast_mode = 1'b0;
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_pixel_x   = '0;
      req_pixel_y   = '0;
      req_red       = '0;
      req_green     = '0;
      req_blue      = '0;
      req_frame_end = 1'b0;
      csr_we        = 1'b0;
      csr_addr      = CSR_REGION_LEFT;
      csr_wdata     = '0;
      cfg_left       = COORD_BITS'(RESET_REGION_LEFT);
      cfg_top        = COORD_BITS'(RESET_REGION_TOP);
      cfg_right      = COORD_BITS'(RESET_REGION_RIGHT);
      cfg_bottom     = COORD_BITS'(RESET_REGION_BOTTOM);
      cfg_min_pixels = COUNT_BITS'(RESET_MIN_PIXELS);
      cfg_tolerance  = COLOR_BITS'(RESET_COLOR_TOL);
      clear_frame();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_color_rules();
      test_box_versus_centroid();
      test_empty_region();
      test_coord_extremes();
      test_output_backpressure();
      test_random_frames();
      wait_idle();

      if (mismatches == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
